### hdl/csp_forward_check_domain_store_unit_macros.svh
// assertion macros for the domain store checker
// each macro expects clk and rst_n in the enclosing scope
`ifndef CSP_FORWARD_CHECK_DOMAIN_STORE_UNIT_MACROS_SVH
`define CSP_FORWARD_CHECK_DOMAIN_STORE_UNIT_MACROS_SVH

// same-cycle implication
`define CSP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/csp_fcds_pkg.sv
package csp_fcds_pkg;

    // operation codes
    typedef enum logic [2:0] {
        OP_CLEAR   = 3'd0,
        OP_LOAD    = 3'd1,
        OP_CLIQUE  = 3'd2,
        OP_BIND    = 3'd3,
        OP_PUSH    = 3'd4,
        OP_RESTORE = 3'd5,
        OP_DISCARD = 3'd6,
        OP_QUERY   = 3'd7
    } opcode_t;

    // result status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_CONFLICT = 2'd1;
    localparam logic [1:0] STAT_FULL     = 2'd2;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_BCHK,
        S_BWALK,
        S_CLIQUE,
        S_PUSH,
        S_RESTORE,
        S_RFIN,
        S_SCAN,
        S_DONE
    } fsm_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic bchk;
        logic bwalk;
        logic clique;
        logic push;
        logic rest_rd;
        logic rest_fin;
        logic scan;
        logic out_load;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        opcode_t op;
        logic    v_ok;
        logic    val_ok;
        logic    push_full;
        logic    stack_empty;
        logic    bind_walk;
        logic    walk_stop;
        logic    idx_last;
        logic    out_free;
    } stat_t;

endpackage

### hdl/csp_fcds_req_if.sv
interface csp_fcds_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [3:0]  var_index;
    logic [3:0]  value_index;
    logic [15:0] bit_mask;

    modport source (output valid, opcode, var_index, value_index, bit_mask, input ready);
    modport sink (input valid, opcode, var_index, value_index, bit_mask, output ready);
endinterface

### hdl/csp_fcds_rsp_if.sv
interface csp_fcds_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] domain_bits;
    logic [4:0]  domain_count;
    logic        is_tracked;
    logic        single_valued;
    logic        unit_found;
    logic [3:0]  unit_var;
    logic        branch_found;
    logic [3:0]  branch_var;
    logic [3:0]  stack_level;

    modport source (output valid, status, domain_bits, domain_count, is_tracked,
        single_valued, unit_found, unit_var, branch_found, branch_var, stack_level,
        input ready);
    modport sink (input valid, status, domain_bits, domain_count, is_tracked,
        single_valued, unit_found, unit_var, branch_found, branch_var, stack_level,
        output ready);
endinterface

### hdl/csp_fcds_ram.sv
module csp_fcds_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

### hdl/csp_fcds_ctrl.sv
module csp_fcds_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  csp_fcds_pkg::stat_t stat,
    output csp_fcds_pkg::cmd_t  cmd
);
    import csp_fcds_pkg::*;

    fsm_state_t state_reg;
    fsm_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (stat.op)
                    OP_BIND:    state_next = (stat.v_ok && stat.val_ok) ? S_BCHK : S_SCAN;
                    OP_CLIQUE:  state_next = S_CLIQUE;
                    OP_PUSH:    state_next = stat.push_full ? S_SCAN : S_PUSH;
                    OP_RESTORE: state_next = stat.stack_empty ? S_SCAN : S_RESTORE;
                    default:    state_next = S_SCAN;
                endcase
            end
            S_BCHK:    state_next = stat.bind_walk ? S_BWALK : S_SCAN;
            S_BWALK:
            begin
                if (stat.walk_stop || stat.idx_last)
                begin
                    state_next = S_SCAN;
                end
            end
            S_CLIQUE:
            begin
                if (stat.idx_last)
                begin
                    state_next = S_SCAN;
                end
            end
            S_PUSH:
            begin
                if (stat.idx_last)
                begin
                    state_next = S_SCAN;
                end
            end
            S_RESTORE:
            begin
                if (stat.idx_last)
                begin
                    state_next = S_RFIN;
                end
            end
            S_RFIN:    state_next = S_SCAN;
            S_SCAN:
            begin
                if (stat.idx_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
            end
            S_EXEC:    cmd.exec     = 1'b1;
            S_BCHK:    cmd.bchk     = 1'b1;
            S_BWALK:   cmd.bwalk    = 1'b1;
            S_CLIQUE:  cmd.clique   = 1'b1;
            S_PUSH:    cmd.push     = 1'b1;
            S_RESTORE: cmd.rest_rd  = 1'b1;
            S_RFIN:    cmd.rest_fin = 1'b1;
            S_SCAN:    cmd.scan     = 1'b1;
            S_DONE:    cmd.out_load = stat.out_free;
            default:   cmd          = '0;
        endcase
    end
endmodule

### hdl/csp_fcds_datapath.sv
module csp_fcds_datapath #(
    parameter int NUM_VARS    = 16,
    parameter int NUM_VALUES  = 16,
    parameter int STACK_DEPTH = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  csp_fcds_pkg::cmd_t  cmd,
    output csp_fcds_pkg::stat_t stat,
    input  logic [2:0]          opcode,
    input  logic [3:0]          var_index,
    input  logic [3:0]          value_index,
    input  logic [15:0]         bit_mask,
    input  logic                rsp_ready,
    output logic                rsp_valid,
    output logic [1:0]          status,
    output logic [15:0]         domain_bits,
    output logic [4:0]          domain_count,
    output logic                is_tracked,
    output logic                single_valued,
    output logic                unit_found,
    output logic [3:0]          unit_var,
    output logic                branch_found,
    output logic [3:0]          branch_var,
    output logic [3:0]          stack_level
);
    import csp_fcds_pkg::*;

    localparam int IDX_W    = $clog2(NUM_VARS);
    localparam int DV_W     = NUM_VALUES;
    localparam int CNT_W    = $clog2(NUM_VALUES + 1);
    localparam int SP_W     = $clog2(STACK_DEPTH + 1);
    localparam int SD_DEPTH = STACK_DEPTH * NUM_VARS;
    localparam int SD_AW    = (SD_DEPTH > 1) ? $clog2(SD_DEPTH) : 1;
    localparam int FL_AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    function automatic logic [CNT_W-1:0] popcnt(input logic [DV_W-1:0] x);
        logic [CNT_W-1:0] n;
        n = '0;
        for (int k = 0; k < DV_W; k++)
        begin
            n = n + CNT_W'(x[k]);
        end
        return n;
    endfunction

    // store state
    logic [DV_W-1:0]     dom_reg [NUM_VARS];
    logic [NUM_VARS-1:0] nbr_reg [NUM_VARS];
    logic [NUM_VARS-1:0] tracked_reg;
    logic [NUM_VARS-1:0] bound_reg;
    logic [SP_W-1:0]     sp_reg;

    // per-item working registers
    opcode_t             op_reg;
    logic [3:0]          var_reg;
    logic [3:0]          val_reg;
    logic [15:0]         mask_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [NUM_VARS-1:0] vnbr_reg;
    logic [1:0]          status_reg;
    logic                rest_wr_reg;
    logic [IDX_W-1:0]    rest_idx_reg;
    logic                ufound_reg;
    logic [IDX_W-1:0]    uvar_reg;
    logic                bfound_reg;
    logic [IDX_W-1:0]    bvar_reg;
    logic [CNT_W-1:0]    best_reg;
    logic [DV_W-1:0]     cap_dom_reg;
    logic                cap_trk_reg;

    // output word
    logic                out_valid_reg;
    logic [1:0]          o_status_reg;
    logic [15:0]         o_dom_reg;
    logic [4:0]          o_cnt_reg;
    logic                o_trk_reg;
    logic                o_single_reg;
    logic                o_ufound_reg;
    logic [3:0]          o_uvar_reg;
    logic                o_bfound_reg;
    logic [3:0]          o_bvar_reg;
    logic [3:0]          o_level_reg;

    // decoded item fields
    logic                v_ok;
    logic                val_ok;
    logic [DV_W-1:0]     valbit;
    logic [NUM_VARS-1:0] clique_m;
    logic [NUM_VARS-1:0] self_bit;
    logic                idx_last;
    logic [DV_W-1:0]     cur_dom;
    logic                cur_trk;
    logic                cur_bnd;
    logic                cur_free;
    logic [CNT_W-1:0]    cur_cnt;
    logic [DV_W-1:0]     narrowed;
    logic                walk_hit;
    logic                walk_stop;
    logic [CNT_W-1:0]    cap_cnt;
    logic                out_free;

    assign v_ok     = int'(var_reg) < NUM_VARS;
    assign val_ok   = int'(val_reg) < NUM_VALUES;
    assign valbit   = DV_W'(1) << val_reg;
    assign clique_m = NUM_VARS'(mask_reg);
    assign self_bit = NUM_VARS'(1) << idx_reg;
    assign idx_last = idx_reg == IDX_W'(NUM_VARS - 1);
    assign cur_dom  = dom_reg[idx_reg];
    assign cur_trk  = tracked_reg[idx_reg];
    assign cur_bnd  = bound_reg[idx_reg];
    assign cur_free = cur_trk && !cur_bnd;
    assign cur_cnt  = popcnt(cur_dom);
    assign narrowed = cur_dom & ~valbit;
    assign walk_hit = vnbr_reg[idx_reg] && cur_free;
    assign walk_stop = walk_hit && (narrowed == '0);
    assign cap_cnt  = popcnt(cap_dom_reg);
    assign out_free = !out_valid_reg || rsp_ready;

    // snapshot memories
    logic [SD_AW-1:0]      sd_addr;
    logic [DV_W-1:0]       sd_rdata;
    logic [FL_AW-1:0]      fl_addr;
    logic [2*NUM_VARS-1:0] fl_rdata;

    assign sd_addr = SD_AW'(int'(sp_reg) * NUM_VARS + int'(idx_reg));
    assign fl_addr = FL_AW'(sp_reg);

    csp_fcds_ram #(
        .WIDTH (DV_W),
        .DEPTH (SD_DEPTH)
    ) u_sd_ram (
        .clk   (clk),
        .we    (cmd.push),
        .waddr (sd_addr),
        .wdata (cur_dom),
        .re    (cmd.rest_rd),
        .raddr (sd_addr),
        .rdata (sd_rdata)
    );

    csp_fcds_ram #(
        .WIDTH (2 * NUM_VARS),
        .DEPTH (STACK_DEPTH)
    ) u_fl_ram (
        .clk   (clk),
        .we    (cmd.push && idx_last),
        .waddr (fl_addr),
        .wdata ({tracked_reg, bound_reg}),
        .re    (cmd.rest_rd),
        .raddr (fl_addr),
        .rdata (fl_rdata)
    );

    // status to controller
    always_comb
    begin
        stat.op          = op_reg;
        stat.v_ok        = v_ok;
        stat.val_ok      = val_ok;
        stat.push_full   = int'(sp_reg) >= STACK_DEPTH;
        stat.stack_empty = sp_reg == '0;
        stat.bind_walk   = cur_trk && ((cur_dom & valbit) != '0);
        stat.walk_stop   = walk_stop;
        stat.idx_last    = idx_last;
        stat.out_free    = out_free;
    end

    // item capture and working registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg       <= OP_QUERY;
            var_reg      <= '0;
            val_reg      <= '0;
            mask_reg     <= '0;
            idx_reg      <= '0;
            vnbr_reg     <= '0;
            status_reg   <= STAT_OK;
            rest_wr_reg  <= 1'b0;
            rest_idx_reg <= '0;
            ufound_reg   <= 1'b0;
            uvar_reg     <= '0;
            bfound_reg   <= 1'b0;
            bvar_reg     <= '0;
            best_reg     <= '0;
            cap_dom_reg  <= '0;
            cap_trk_reg  <= 1'b0;
        end
        else
        begin
            rest_wr_reg  <= cmd.rest_rd;
            rest_idx_reg <= idx_reg;
            if (cmd.capture)
            begin
                op_reg      <= opcode_t'(opcode);
                var_reg     <= var_index;
                val_reg     <= value_index;
                mask_reg    <= bit_mask;
                status_reg  <= STAT_OK;
                ufound_reg  <= 1'b0;
                uvar_reg    <= '0;
                bfound_reg  <= 1'b0;
                bvar_reg    <= '0;
                best_reg    <= '0;
                cap_dom_reg <= '0;
                cap_trk_reg <= 1'b0;
            end
            // item index: points at the bound variable first, else walks from zero
            if (cmd.exec)
            begin
                idx_reg <= (op_reg == OP_BIND) ? IDX_W'(var_reg) : '0;
                if (op_reg == OP_BIND && v_ok && !val_ok)
                begin
                    status_reg <= STAT_CONFLICT;
                end
                if (op_reg == OP_PUSH && int'(sp_reg) >= STACK_DEPTH)
                begin
                    status_reg <= STAT_FULL;
                end
            end
            else if (cmd.bchk || cmd.rest_fin)
            begin
                idx_reg <= '0;
            end
            else if (cmd.bwalk || cmd.clique || cmd.push || cmd.rest_rd || cmd.scan)
            begin
                idx_reg <= (idx_last || (cmd.bwalk && walk_stop)) ? '0 : idx_reg + 1'b1;
            end
            // bind check on the addressed variable
            if (cmd.bchk)
            begin
                vnbr_reg <= nbr_reg[idx_reg];
                if (cur_trk && (cur_dom & valbit) == '0)
                begin
                    status_reg <= STAT_CONFLICT;
                end
            end
            if (cmd.bwalk && walk_stop)
            begin
                status_reg <= STAT_CONFLICT;
            end
            // candidate scan, lowest index wins ties
            if (cmd.scan)
            begin
                if (cur_free && cur_cnt == CNT_W'(1) && !ufound_reg)
                begin
                    ufound_reg <= 1'b1;
                    uvar_reg   <= idx_reg;
                end
                if (cur_free && cur_cnt > CNT_W'(1) && (!bfound_reg || cur_cnt < best_reg))
                begin
                    bfound_reg <= 1'b1;
                    bvar_reg   <= idx_reg;
                    best_reg   <= cur_cnt;
                end
                if (v_ok && int'(idx_reg) == int'(var_reg))
                begin
                    cap_dom_reg <= cur_dom;
                    cap_trk_reg <= cur_trk;
                end
            end
        end
    end

    // domain store, flags and stack pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_VARS; i++)
            begin
                dom_reg[i] <= '0;
                nbr_reg[i] <= '0;
            end
            tracked_reg <= '0;
            bound_reg   <= '0;
            sp_reg      <= '0;
        end
        else
        begin
            if (cmd.exec)
            begin
                case (op_reg)
                    OP_CLEAR:
                    begin
                        for (int i = 0; i < NUM_VARS; i++)
                        begin
                            dom_reg[i] <= '0;
                            nbr_reg[i] <= '0;
                        end
                        tracked_reg <= '0;
                        bound_reg   <= '0;
                        sp_reg      <= '0;
                    end
                    OP_LOAD:
                    begin
                        if (v_ok)
                        begin
                            dom_reg[IDX_W'(var_reg)]     <= DV_W'(mask_reg);
                            tracked_reg[IDX_W'(var_reg)] <= 1'b1;
                        end
                    end
                    OP_RESTORE, OP_DISCARD:
                    begin
                        if (sp_reg != '0)
                        begin
                            sp_reg <= sp_reg - 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            // bind on the addressed variable
            if (cmd.bchk)
            begin
                if (!cur_trk)
                begin
                    dom_reg[idx_reg]     <= valbit;
                    tracked_reg[idx_reg] <= 1'b1;
                    bound_reg[idx_reg]   <= 1'b1;
                end
                else if ((cur_dom & valbit) != '0)
                begin
                    dom_reg[idx_reg]   <= valbit;
                    bound_reg[idx_reg] <= 1'b1;
                end
            end
            // neighbor narrowing
            if (cmd.bwalk && walk_hit)
            begin
                dom_reg[idx_reg] <= narrowed;
            end
            // clique row update
            if (cmd.clique && clique_m[idx_reg])
            begin
                nbr_reg[idx_reg] <= nbr_reg[idx_reg] | (clique_m & ~self_bit);
            end
            if (cmd.push && idx_last)
            begin
                sp_reg <= sp_reg + 1'b1;
            end
            // restore write-back, in the cycle after the read
            if (rest_wr_reg)
            begin
                dom_reg[rest_idx_reg] <= sd_rdata;
            end
            if (cmd.rest_fin)
            begin
                tracked_reg <= fl_rdata[2*NUM_VARS-1:NUM_VARS];
                bound_reg   <= fl_rdata[NUM_VARS-1:0];
            end
        end
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            o_status_reg <= status_reg;
            o_dom_reg    <= 16'(cap_dom_reg);
            o_cnt_reg    <= 5'(cap_cnt);
            o_trk_reg    <= cap_trk_reg;
            o_single_reg <= cap_trk_reg && cap_cnt == CNT_W'(1);
            o_ufound_reg <= ufound_reg;
            o_uvar_reg   <= 4'(uvar_reg);
            o_bfound_reg <= bfound_reg;
            o_bvar_reg   <= 4'(bvar_reg);
            o_level_reg  <= 4'(sp_reg);
        end
    end

    assign rsp_valid     = out_valid_reg;
    assign status        = o_status_reg;
    assign domain_bits   = o_dom_reg;
    assign domain_count  = o_cnt_reg;
    assign is_tracked    = o_trk_reg;
    assign single_valued = o_single_reg;
    assign unit_found    = o_ufound_reg;
    assign unit_var      = o_uvar_reg;
    assign branch_found  = o_bfound_reg;
    assign branch_var    = o_bvar_reg;
    assign stack_level   = o_level_reg;
endmodule

### hdl/csp_forward_check_domain_store_unit.sv
// every item passes execute, candidate scan and result states; bind adds a check and a neighbor walk
// clique and push add a pass over the variables, restore adds a read pass and a flag reload
// the neighbor walk, the snapshot copy and the candidate scan each visit one variable a cycle
// throughput: one item at a time, next item taken once the result enters the output register
// reset: asynchronous active low, empties all domains, flags, neighbors and the stack
module csp_forward_check_domain_store_unit #(
    parameter int NUM_VARS    = 16,
    parameter int NUM_VALUES  = 16,
    parameter int STACK_DEPTH = 8
) (
    input logic          clk,
    input logic          rst_n,
    csp_fcds_req_if.sink   req,
    csp_fcds_rsp_if.source rsp
);
    import csp_fcds_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // sequencer
    csp_fcds_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // store and result logic
    csp_fcds_datapath #(
        .NUM_VARS    (NUM_VARS),
        .NUM_VALUES  (NUM_VALUES),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .opcode        (req.opcode),
        .var_index     (req.var_index),
        .value_index   (req.value_index),
        .bit_mask      (req.bit_mask),
        .rsp_ready     (rsp.ready),
        .rsp_valid     (rsp.valid),
        .status        (rsp.status),
        .domain_bits   (rsp.domain_bits),
        .domain_count  (rsp.domain_count),
        .is_tracked    (rsp.is_tracked),
        .single_valued (rsp.single_valued),
        .unit_found    (rsp.unit_found),
        .unit_var      (rsp.unit_var),
        .branch_found  (rsp.branch_found),
        .branch_var    (rsp.branch_var),
        .stack_level   (rsp.stack_level)
    );
endmodule

### hdl/csp_fcds_checker.sv
`include "csp_forward_check_domain_store_unit_macros.svh"

module csp_fcds_checker #(
    parameter int STACK_DEPTH = 8
) (
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [1:0]  status,
    input logic [4:0]  domain_count,
    input logic        is_tracked,
    input logic        single_valued,
    input logic        unit_found,
    input logic [3:0]  unit_var,
    input logic [3:0]  stack_level
);
    import csp_fcds_pkg::*;

    // stalled word holds
    `CSP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(domain_count) && $stable(stack_level), "result word changed while stalled")

    // refused push only at a full stack
    `CSP_ASSERT_IMP(a_full_level, rsp_valid && status == STAT_FULL, int'(stack_level) == STACK_DEPTH, "stack full reported below depth")

    // single value implies tracked with count one
    `CSP_ASSERT_IMP(a_single, rsp_valid && single_valued, is_tracked && domain_count == 5'd1, "single value flag inconsistent")

    // no unit means index zero
    `CSP_ASSERT_IMP(a_unit_zero, rsp_valid && !unit_found, unit_var == 4'd0, "unit index set without a unit")
endmodule

bind csp_forward_check_domain_store_unit csp_fcds_checker #(
    .STACK_DEPTH (STACK_DEPTH)
) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .status        (rsp.status),
    .domain_count  (rsp.domain_count),
    .is_tracked    (rsp.is_tracked),
    .single_valued (rsp.single_valued),
    .unit_found    (rsp.unit_found),
    .unit_var      (rsp.unit_var),
    .stack_level   (rsp.stack_level)
);
